/* sv/mtq_pkg.sv */
// Shared types and codes for the max-tracking FIFO.
package mtq_pkg;

    // item kinds on the input tuser
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // error codes in the result item
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    localparam int COUNT_W = 5;

    // per-cell control from the top level
    typedef struct packed {
        logic push;   // accepted push, queue not full
        logic pop;    // accepted pop, queue not empty
        logic held;   // cell holds an entry before this item
        logic load;   // cell is the new tail on this push
    } mtq_ctrl_t;

endpackage

/* sv/mtq_cell.sv */
// One queue cell: an entry value and the maximum of it and all later entries.
module mtq_cell
    import mtq_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  mtq_ctrl_t             ctrl,
    input  logic [DATA_WIDTH-1:0] push_value,
    input  logic [DATA_WIDTH-1:0] nbr_value,   // from the cell behind
    input  logic [DATA_WIDTH-1:0] nbr_max,
    output logic [DATA_WIDTH-1:0] value,
    output logic [DATA_WIDTH-1:0] max
);

    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [DATA_WIDTH-1:0] max_reg, max_next;
    logic                  raise;

    assign raise = $signed(push_value) > $signed(max_reg);

    always_comb
    begin
        value_next = value_reg;
        max_next   = max_reg;
        if (ctrl.pop)
        begin
            // whole row moves one place toward the head
            value_next = nbr_value;
            max_next   = nbr_max;
        end
        else if (ctrl.push)
        begin
            if (ctrl.load)
            begin
                value_next = push_value;
                max_next   = push_value;
            end
            else if (ctrl.held && raise)
            begin
                max_next = push_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        max_reg   <= max_next;
    end

    assign value = value_reg;
    assign max   = max_reg;

endmodule

/* sv/max_tracking_fifo.sv */
// Top level of the max-tracking FIFO: control, cell row and result port.
//
// A FIFO of DEPTH signed DATA_WIDTH-bit values that also reports the largest
// value held. Input items (tuser = kind: 0 push, 1 pop; tdata = value) are
// taken one per clock unless the result port stalls; each produces exactly one
// result item in the next cycle with the front value, the queue maximum, the
// entry count, an empty flag and an error code (1 push refused because full,
// 2 pop refused because empty; a refused item leaves the queue as it was).
// The storage is a row of DEPTH identical cells with the head always in cell
// 0: a push writes the cell at position count and every held cell raises its
// suffix maximum to the new value if that is larger, in the same cycle; a pop
// shifts the whole row one cell toward the head. Throughput is one item per
// cycle, set by the parallel update of the cell row. The result is taken
// straight from the registers of cell 0 and the count, so a new item is
// accepted whenever the pending result is taken in the same cycle or none is
// pending. Entries of an empty queue read as 0; the count field is the low 5
// bits of the internal count.
module max_tracking_fifo
    import mtq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: value (DATA_WIDTH, signed), zero padded to whole bytes
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]        s_tdata,
    // tuser: kind (1 bit)
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: front_value (DATA_WIDTH), max_value (DATA_WIDTH), count (5),
    //        is_empty (1), error (2), zero padded to whole bytes
    output logic [((2*DATA_WIDTH+8+7)/8)*8-1:0]    m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((2*DATA_WIDTH+8+7)/8)*8;

    logic                  accept;
    logic                  is_push;
    logic                  full;
    logic                  empty;
    logic                  push_ok;
    logic                  pop_ok;
    logic [DATA_WIDTH-1:0] push_value;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [1:0]            err_reg, err_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    mtq_ctrl_t             cell_ctrl [DEPTH];
    // one extra slot feeds the last cell on a pop
    logic [DATA_WIDTH-1:0] cell_value [DEPTH+1];
    logic [DATA_WIDTH-1:0] cell_max   [DEPTH+1];

    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] max_value;
    logic                  is_empty;

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign is_push    = (s_tuser == KIND_PUSH);
    assign push_value = s_tdata[DATA_WIDTH-1:0];
    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign empty      = (cnt_reg == '0);
    assign push_ok    = accept && is_push && !full;
    assign pop_ok     = accept && !is_push && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        err_next = err_reg;
        if (accept)
        begin
            err_next = ERR_NONE;
            if (is_push)
            begin
                if (full)
                    err_next = ERR_FULL;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            else
            begin
                if (empty)
                    err_next = ERR_EMPTY;
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (accept)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            err_reg      <= ERR_NONE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // cell row, head in cell 0
    assign cell_value[DEPTH] = '0;
    assign cell_max[DEPTH]   = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign cell_ctrl[i].push = push_ok;
        assign cell_ctrl[i].pop  = pop_ok;
        assign cell_ctrl[i].held = (cnt_reg > CNT_W'(i));
        assign cell_ctrl[i].load = (cnt_reg == CNT_W'(i));

        mtq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .push_value (push_value),
            .nbr_value  (cell_value[i+1]),
            .nbr_max    (cell_max[i+1]),
            .value      (cell_value[i]),
            .max        (cell_max[i])
        );
    end

    // result from the state left by the last item
    assign is_empty    = (cnt_reg == '0);
    assign front_value = is_empty ? '0 : cell_value[0];
    assign max_value   = is_empty ? '0 : cell_max[0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({err_reg, is_empty, COUNT_W'(cnt_reg), max_value, front_value});

    // count never exceeds the number of cells
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // a refused item leaves the count alone
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((is_push && full) || (!is_push && empty)) |=> $stable(cnt_reg))
        else $error("refused item changed the count");

    // the head's suffix maximum bounds the front value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !is_empty |-> $signed(cell_max[0]) >= $signed(cell_value[0]))
        else $error("queue maximum below front value");

endmodule
